// ===== hw/rtl/htcm_pkg.sv =====
`default_nettype none
package htcm_pkg;

  // Format defaults
  localparam int unsigned InputIntBits = 8;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CurveW       = 2;

  // Curve select codes
  localparam logic [CurveW-1:0] CurveAces     = 2'd0;
  localparam logic [CurveW-1:0] CurveFilmic   = 2'd1;
  localparam logic [CurveW-1:0] CurveReinhard = 2'd2;
  localparam logic [CurveW-1:0] CurvePass     = 2'd3;

  // Side-band that travels with each item through the divider
  typedef struct packed {
    logic valid;
    logic sat;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/htcm_prep.sv =====
`default_nettype none
// Two stages: square the sample, then form numerator and denominator.
module htcm_prep #(
  parameter int unsigned InW = 24,
  parameter int unsigned Frac = 16,
  parameter int unsigned DW = 2 * InW + 9
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [InW-1:0]                 x_i,
  input  wire logic [htcm_pkg::CurveW-1:0]    curve_i,
  output htcm_pkg::ctrl_t                     ctrl_o,
  output logic [DW-1:0]                       num_o,
  output logic [DW-1:0]                       den_o
);

  localparam int unsigned SqW = 2 * InW;
  localparam logic [DW-1:0] OutMax = DW'((64'd1 << (Frac + 1)) - 64'd1);

  logic                        va_q;
  logic [InW-1:0]              xa_q;
  logic [SqW-1:0]              sq_q;
  logic [htcm_pkg::CurveW-1:0] ca_q;

  // Stage A: square
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q <= x_i;
    ca_q <= curve_i;
    sq_q <= x_i * x_i;
  end

  // Stage B: rational terms, all exact
  logic [DW-1:0] x_w, sq_w, one_w;
  logic [DW-1:0] num_d, den_d;
  logic          sat_d;

  always_comb begin
    x_w   = DW'(xa_q);
    sq_w  = DW'(sq_q);
    one_w = DW'(1) << Frac;
    sat_d = 1'b0;
    case (ca_q)
      htcm_pkg::CurveAces: begin
        num_d = DW'(251) * sq_w + ((DW'(3) * x_w) << Frac);
        den_d = DW'(243) * sq_w + ((DW'(59) * x_w) << Frac) + (DW'(14) << (2 * Frac));
      end
      htcm_pkg::CurveFilmic: begin
        num_d = DW'(42) * sq_w + ((DW'(5) * x_w) << Frac);
        den_d = DW'(45) * sq_w + ((DW'(150) * x_w) << Frac) + (DW'(18) << (2 * Frac));
      end
      htcm_pkg::CurveReinhard: begin
        num_d = x_w;
        den_d = one_w + x_w;
      end
      default: begin
        // passthrough: x / 1 through the divider, saturate large values
        sat_d = (x_w > OutMax);
        num_d = sat_d ? '0 : x_w;
        den_d = one_w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else begin
      ctrl_o.valid <= va_q;
      ctrl_o.sat   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_o <= num_d;
    den_o <= den_d;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/htcm_div_stage.sv =====
`default_nettype none
// One restoring-division step: one quotient bit per stage.
module htcm_div_stage #(
  parameter int unsigned DW = 57,
  parameter int unsigned QW = 18,
  parameter bit          First = 1'b0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire htcm_pkg::ctrl_t ctrl_i,
  input  wire logic [DW-1:0]   rem_i,
  input  wire logic [DW-1:0]   den_i,
  input  wire logic [QW-1:0]   quo_i,
  output htcm_pkg::ctrl_t      ctrl_o,
  output logic [DW-1:0]        rem_o,
  output logic [DW-1:0]        den_o,
  output logic [QW-1:0]        quo_o
);

  logic [DW:0] part;
  logic        ge;
  logic [DW:0] diff;

  // shift in a zero (except on the integer step), trial subtract
  always_comb begin
    part = First ? {1'b0, rem_i} : {rem_i, 1'b0};
    ge   = (part >= {1'b0, den_i});
    diff = part - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= ge ? diff[DW-1:0] : part[DW-1:0];
    den_o <= den_i;
    quo_o <= {quo_i[QW-2:0], ge};
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hdr_tone_curve_mapper_unit.sv =====
`default_nettype none
// Channel   | Direction | Signals                            | Transfer
// ----------+-----------+------------------------------------+---------------------------
// sample in | in        | start_i, busy_o, hdr_sample_i      | start_i & !busy_o
// result    | out       | ldr_valid_o, ldr_sample_o          | ldr_valid_o (one cycle)
// config    | in        | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i & cfg_ready_o
//
// One sample a cycle, through two prep stages, one divider stage per quotient bit
// (FRAC_BITS + 2) and one rounding/output stage.
// busy_o stays low; the receiver cannot stall, results flow every cycle.
// Reset clears the valid bits and sets the curve to ACES.
module hdr_tone_curve_mapper_unit #(
  parameter int unsigned INPUT_INT_BITS = htcm_pkg::InputIntBits,
  parameter int unsigned FRAC_BITS      = htcm_pkg::FracBits
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [INPUT_INT_BITS+FRAC_BITS-1:0]  hdr_sample_i,
  output logic                                      ldr_valid_o,
  output logic [FRAC_BITS:0]                        ldr_sample_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [htcm_pkg::CurveW-1:0]          cfg_data_i
);

  localparam int unsigned InW = INPUT_INT_BITS + FRAC_BITS;
  localparam int unsigned DW  = 2 * InW + 9;
  localparam int unsigned QW  = FRAC_BITS + 2;
  localparam int unsigned NS  = QW;
  localparam logic [QW:0] OutMax = (QW+1)'((64'd1 << (FRAC_BITS + 1)) - 64'd1);

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Curve register
  logic [htcm_pkg::CurveW-1:0] curve_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= htcm_pkg::CurveAces;
    end else if (cfg_valid_i) begin
      curve_q <= cfg_data_i;
    end
  end

  // Numerator / denominator
  htcm_pkg::ctrl_t ctrl_s [NS+1];
  logic [DW-1:0]   rem_s  [NS+1];
  logic [DW-1:0]   den_s  [NS+1];
  logic [QW-1:0]   quo_s  [NS+1];

  htcm_prep #(.InW(InW), .Frac(FRAC_BITS), .DW(DW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .x_i     (hdr_sample_i),
    .curve_i (curve_q),
    .ctrl_o  (ctrl_s[0]),
    .num_o   (rem_s[0]),
    .den_o   (den_s[0])
  );
  assign quo_s[0] = '0;

  // Divider pipeline
  for (genvar k = 0; k < NS; k++) begin : g_div
    htcm_div_stage #(.DW(DW), .QW(QW), .First(k == 0)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_s[k]),
      .rem_i  (rem_s[k]),
      .den_i  (den_s[k]),
      .quo_i  (quo_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .den_o  (den_s[k+1]),
      .quo_o  (quo_s[k+1])
    );
  end

  // Round half up from the extra quotient bit, then saturate
  logic [QW:0]      rnd;
  logic [FRAC_BITS:0] y_d;
  always_comb begin
    rnd = ({1'b0, quo_s[NS]} + (QW+1)'(1)) >> 1;
    y_d = (ctrl_s[NS].sat || rnd > OutMax) ? OutMax[FRAC_BITS:0] : rnd[FRAC_BITS:0];
  end

  logic               valid_q;
  logic [FRAC_BITS:0] y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_s[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign ldr_valid_o  = valid_q;
  assign ldr_sample_o = y_q;

endmodule
`default_nettype wire
